@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

@@ rtl/sce_pkg.sv @@
// ----------------------------------------------------------------------------
// sce_pkg
// shared types, constants and the letter code table of the soundex encoder
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int CODE_LENGTH   = 4;
  localparam int NUM_DIGITS    = CODE_LENGTH - 1;
  localparam int REPORT_DIGITS = (NUM_DIGITS < 3) ? NUM_DIGITS : 3;
  localparam int CNT_W         = $clog2(NUM_DIGITS + 1);
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [4:0] IDX_H = 5'd7;
  localparam logic [4:0] IDX_W = 5'd22;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  // classified word in the queue between front and back
  typedef struct packed {
    logic       is_letter;
    logic [4:0] idx;
    logic [2:0] code;
    logic       eos;
  } sce_item_t;

  typedef struct packed {
    logic [7:0] first_letter;
    logic [2:0] digit_one;
    logic [2:0] digit_two;
    logic [2:0] digit_three;
    logic       is_empty;
  } sce_result_t;

  // soundex digit of letter index 0..25
  function automatic logic [2:0] code_of(input logic [4:0] idx);
    logic [2:0] c;
    case (idx)
      5'd1, 5'd5, 5'd15, 5'd21:                       c = 3'd1;
      5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: c = 3'd2;
      5'd3, 5'd19:                                    c = 3'd3;
      5'd11:                                          c = 3'd4;
      5'd12, 5'd13:                                   c = 3'd5;
      5'd17:                                          c = 3'd6;
      default:                                        c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic is_hw(input logic [4:0] idx);
    return (idx == IDX_H) || (idx == IDX_W);
  endfunction

endpackage

@@ rtl/sce_front.sv @@
// ----------------------------------------------------------------------------
// sce_front
// classifies incoming bytes and buffers them in a two-entry queue
// ----------------------------------------------------------------------------
module sce_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [7:0]        char_i,
  input  logic              char_valid_i,
  input  logic              eos_i,
  output logic              q_valid_o,
  output sce_pkg::sce_item_t q_item_o,
  input  logic              q_pop_i
);
  import sce_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  sce_item_t             entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]        count_q, count_d;
  logic [7:0]            upper;
  logic                  letter;
  sce_item_t             item;
  logic                  push;

  always_comb begin
    upper = char_i;
    if (char_i >= CHAR_LOWER_A && char_i <= CHAR_LOWER_Z) begin
      upper = char_i - 8'd32;
    end
    letter         = char_valid_i && upper >= CHAR_UPPER_A && upper <= CHAR_UPPER_Z;
    item.is_letter = letter;
    item.idx       = 5'(upper - CHAR_UPPER_A);
    item.code      = code_of(item.idx);
    item.eos       = eos_i;
  end

  assign s_ready_o = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
  // words that neither add a letter nor close the string are dropped here
  assign push      = s_valid_i && s_ready_o && (letter || eos_i);
  assign q_valid_o = (count_q != '0);
  assign q_item_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= item;
    end
  end

endmodule

@@ rtl/sce_back.sv @@
// ----------------------------------------------------------------------------
// sce_back
// soundex state update per letter and registered result output
// ----------------------------------------------------------------------------
module sce_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  sce_pkg::sce_item_t  q_item_i,
  output logic                q_pop_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output sce_pkg::sce_result_t m_result_o
);
  import sce_pkg::*;

  logic             have_first_q, have_first_d;
  logic [4:0]       first_idx_q, first_idx_d;
  logic [2:0]       held_q [3];
  logic [2:0]       held_d [3];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             full_q, full_d;
  logic [2:0]       prev_q, prev_d;
  logic [4:0]       back_one_q, back_one_d;
  logic [4:0]       back_two_q, back_two_d;
  logic             seen_two_q, seen_two_d;
  logic             out_valid_q, out_valid_d;
  sce_result_t      out_q, out_d;
  logic             skip;
  logic             emit;

  // a closing word waits only if the output register cannot be freed
  assign q_pop_o    = q_valid_i && (!q_item_i.eos || !out_valid_q || m_ready_i);
  assign m_valid_o  = out_valid_q;
  assign m_result_o = out_q;

  always_comb begin
    have_first_d = have_first_q;
    first_idx_d  = first_idx_q;
    held_d       = held_q;
    cnt_d        = cnt_q;
    full_d       = full_q;
    prev_d       = prev_q;
    back_one_d   = back_one_q;
    back_two_d   = back_two_q;
    seen_two_d   = seen_two_q;
    out_valid_d  = out_valid_q && !m_ready_i;
    out_d        = out_q;
    skip         = 1'b0;
    emit         = 1'b0;

    if (q_pop_o && q_item_i.is_letter) begin
      if (!have_first_q) begin
        have_first_d = 1'b1;
        first_idx_d  = q_item_i.idx;
        prev_d       = q_item_i.code;
        back_one_d   = q_item_i.idx;
      end else if (!full_q) begin
        // h/w rule: letter after h or w merges with the one before it
        skip = seen_two_q && q_item_i.code != 3'd0 && is_hw(back_one_q) &&
               (code_of(back_two_q) == q_item_i.code || is_hw(back_two_q));
        if (!skip) begin
          emit = q_item_i.code != 3'd0 && q_item_i.code != prev_q;
          if (emit) begin
            for (int k = 0; k < 3; k++) begin
              if (k < REPORT_DIGITS && int'(cnt_q) == k) begin
                held_d[k] = q_item_i.code;
              end
            end
            cnt_d = cnt_q + 1'b1;
            if (int'(cnt_d) >= NUM_DIGITS) begin
              full_d = 1'b1;
            end
          end
          prev_d = q_item_i.code;
        end
        back_two_d = back_one_q;
        back_one_d = q_item_i.idx;
        seen_two_d = 1'b1;
      end
    end

    if (q_pop_o && q_item_i.eos) begin
      out_valid_d = 1'b1;
      if (have_first_d) begin
        out_d.first_letter = CHAR_UPPER_A + {3'b000, first_idx_d};
        out_d.digit_one    = held_d[0];
        out_d.digit_two    = held_d[1];
        out_d.digit_three  = held_d[2];
        out_d.is_empty     = 1'b0;
      end else begin
        out_d = '0;
        out_d.is_empty = 1'b1;
      end
      have_first_d = 1'b0;
      first_idx_d  = '0;
      held_d       = '{default: '0};
      cnt_d        = '0;
      full_d       = 1'b0;
      prev_d       = '0;
      back_one_d   = '0;
      back_two_d   = '0;
      seen_two_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_first_q <= 1'b0;
      first_idx_q  <= '0;
      held_q       <= '{default: '0};
      cnt_q        <= '0;
      full_q       <= 1'b0;
      prev_q       <= '0;
      back_one_q   <= '0;
      back_two_q   <= '0;
      seen_two_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      have_first_q <= have_first_d;
      first_idx_q  <= first_idx_d;
      held_q       <= held_d;
      cnt_q        <= cnt_d;
      full_q       <= full_d;
      prev_q       <= prev_d;
      back_one_q   <= back_one_d;
      back_two_q   <= back_two_d;
      seen_two_q   <= seen_two_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

@@ rtl/soundex_code_encoder_core.sv @@
// ----------------------------------------------------------------------------
// soundex_code_encoder_core
// streaming soundex encoder, one byte per word, one code per string
// ----------------------------------------------------------------------------
// input stream: one string byte per word on tdata, tuser high when the byte
// is present, tlast on the final word of the string. a word with tuser low
// and tlast high closes the string without adding a byte.
// output stream: one word per string, sent for the word that carries tlast.
// tuser is set when the string held no letters, tdata is then zero.
// the front classifies each byte and parks it in a two-entry queue; the
// back updates the code state one word per cycle and fills an output
// register. throughput is one word per cycle while no closing word waits
// on a stalled receiver, limited by the single state update in the back.
// a closing word passes through the queue, then the output register.
// reset empties the queue, clears the code state and the output valid flag.
// while the receiver stalls a finished code stays in the output register,
// letters keep flowing, and only the next closing word waits; once the
// queue is full tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module soundex_code_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] character
  input  logic        s_axis_tuser_i,  // [0] char_valid
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [7:0] first_letter, [10:8] digit_one,
                                       // [13:11] digit_two, [16:14] digit_three
  output logic        m_axis_tuser_o   // [0] is_empty
);
  import sce_pkg::*;

  logic        q_valid;
  sce_item_t   q_item;
  logic        q_pop;
  sce_result_t result;

  sce_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .char_i       (s_axis_tdata_i),
    .char_valid_i (s_axis_tuser_i),
    .eos_i        (s_axis_tlast_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  sce_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_result_o (result)
  );

  assign m_axis_tdata_o = {7'd0, result.digit_three, result.digit_two,
                           result.digit_one, result.first_letter};
  assign m_axis_tuser_o = result.is_empty;

  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, q_pop && !q_valid, "pop from empty queue")
  `ASSERT_CLK(a_empty_zero, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == 24'd0), "empty code with data")
  `ASSERT_CLK(a_letter_range, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[7:0] >= CHAR_UPPER_A && m_axis_tdata_o[7:0] <= CHAR_UPPER_Z), "first letter out of range")

endmodule
